// ===== rtl/kstq_pkg.sv =====
`default_nettype none

package kstq_pkg;

   // request codes
   localparam logic [1:0] REQ_KEY  = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_PUSH = 2'd2;

   // key table kinds
   localparam logic [3:0] KIND_UNMAPPED = 4'd0;
   localparam logic [3:0] KIND_LETTER   = 4'd1;
   localparam logic [3:0] KIND_ASCII    = 4'd2;
   localparam logic [3:0] KIND_NUMPAD   = 4'd3;
   localparam logic [3:0] KIND_FUNC     = 4'd4;
   localparam logic [3:0] KIND_LSHIFT   = 4'd5;
   localparam logic [3:0] KIND_RSHIFT   = 4'd6;
   localparam logic [3:0] KIND_CTRL     = 4'd7;
   localparam logic [3:0] KIND_ALT      = 4'd8;
   localparam logic [3:0] KIND_CAPS     = 4'd9;
   localparam logic [3:0] KIND_NUM      = 4'd10;
   localparam logic [3:0] KIND_SCROLL   = 4'd11;

   // shift-flag byte bits
   localparam logic [7:0] MASK_RSHIFT = 8'h01;
   localparam logic [7:0] MASK_LSHIFT = 8'h02;
   localparam logic [7:0] MASK_CTRL   = 8'h04;
   localparam logic [7:0] MASK_ALT    = 8'h08;
   localparam logic [7:0] MASK_SCROLL = 8'h10;
   localparam logic [7:0] MASK_NUM    = 8'h20;
   localparam logic [7:0] MASK_CAPS   = 8'h40;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_DONE
   } kstq_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic publish;
   } kstq_cmd_type;

   typedef struct packed {
      logic out_free;
   } kstq_sts_type;

   // Character half of a translated word, from the flags before the event.
   function automatic logic [7:0] translate_char(input logic [3:0] kind,
                                                 input logic [7:0] flags,
                                                 input logic [7:0] plain,
                                                 input logic [7:0] upper,
                                                 input logic [7:0] pad);
      logic shift;
      logic ctrl;
      logic caps;
      logic numl;
      logic [7:0] ch;
      shift = (flags & (MASK_LSHIFT | MASK_RSHIFT)) != 8'h00;
      ctrl  = (flags & MASK_CTRL) != 8'h00;
      caps  = (flags & MASK_CAPS) != 8'h00;
      numl  = (flags & MASK_NUM) != 8'h00;
      ch    = 8'h00;
      if (kind == KIND_LETTER) begin
         if (ctrl) ch = plain - CHAR_LOWER_A + 8'd1;
         else if (shift != caps) ch = plain - CHAR_LOWER_A + CHAR_UPPER_A;
         else ch = plain;
      end else if (kind == KIND_ASCII) begin
         ch = shift ? upper : plain;
      end else if (kind == KIND_NUMPAD) begin
         ch = (numl != shift) ? pad : 8'h00;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/keyboard_scancode_translate_queue_unit.sv =====
// Keyboard scancode translator with a keystroke ring.
// An accepted request beat passes EXEC, PEEK and DONE to the result register.
// One request at a time (stall until IDLE); the registered ring read port is
//   used twice per request (head word before the update, new head after it).
// Reset (synchronous, active high) clears flags, lock-held bits, break flag,
//   ring pointers and the result valid; ring contents are left as they are.
`default_nettype none

module keyboard_scancode_translate_queue_unit #(
   parameter int RING_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_scancode,
   input  wire logic        req_key_down,
   input  wire logic [3:0]  req_key_kind,
   input  wire logic [7:0]  req_plain_char,
   input  wire logic [7:0]  req_upper_char,
   input  wire logic [7:0]  req_pad_char,
   input  wire logic [15:0] req_keystroke,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_popped_word,
   output logic             rsp_pop_ok,
   output logic             rsp_push_ok,
   output logic             rsp_ring_empty,
   output logic [15:0]      rsp_head_preview,
   output logic [7:0]       rsp_flag_byte,
   output logic             rsp_break_event,
   output logic             rsp_break_latched
);

   // Controller walks IDLE -> EXEC -> PEEK -> DONE:
   //   IDLE  takes the request beat; the ring head word is already being read.
   //   EXEC  applies flags / lock keys / break, pushes or pops, moves pointers.
   //   PEEK  lets the registered read pick up the word at the new head.
   //   DONE  loads the response register once it is free (or being drained).
   // The response register lets a finished beat wait on rsp_stall while the
   // controller returns to IDLE only after handing it over.
   kstq_pkg::kstq_cmd_type cmd;
   kstq_pkg::kstq_sts_type sts;

   kstq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: request capture, shift-flag byte, translation, ring memory
   // (RING_SLOTS entries, one slot kept empty to tell full from empty).
   kstq_dp #(
      .RING_SLOTS (RING_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_scancode      (req_scancode),
      .req_key_down      (req_key_down),
      .req_key_kind      (req_key_kind),
      .req_plain_char    (req_plain_char),
      .req_upper_char    (req_upper_char),
      .req_pad_char      (req_pad_char),
      .req_keystroke     (req_keystroke),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_popped_word   (rsp_popped_word),
      .rsp_pop_ok        (rsp_pop_ok),
      .rsp_push_ok       (rsp_push_ok),
      .rsp_ring_empty    (rsp_ring_empty),
      .rsp_head_preview  (rsp_head_preview),
      .rsp_flag_byte     (rsp_flag_byte),
      .rsp_break_event   (rsp_break_event),
      .rsp_break_latched (rsp_break_latched)
   );

endmodule

`default_nettype wire

// ===== rtl/kstq_ctrl.sv =====
`default_nettype none

module kstq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  kstq_pkg::kstq_sts_type     sts,
   output kstq_pkg::kstq_cmd_type     cmd
);

   kstq_pkg::kstq_state_type state_ff;
   kstq_pkg::kstq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kstq_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kstq_pkg::ST_IDLE: if (req_valid) state_in = kstq_pkg::ST_EXEC;
         kstq_pkg::ST_EXEC: state_in = kstq_pkg::ST_PEEK;
         kstq_pkg::ST_PEEK: state_in = kstq_pkg::ST_DONE;
         kstq_pkg::ST_DONE: if (sts.out_free) state_in = kstq_pkg::ST_IDLE;
         default: state_in = kstq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != kstq_pkg::ST_IDLE);
      cmd.capture = (state_ff == kstq_pkg::ST_IDLE) && req_valid;
      cmd.execute = (state_ff == kstq_pkg::ST_EXEC);
      cmd.publish = (state_ff == kstq_pkg::ST_DONE) && sts.out_free;
   end

endmodule

`default_nettype wire

// ===== rtl/kstq_dp.sv =====
`default_nettype none

module kstq_dp #(
   parameter int RING_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  kstq_pkg::kstq_cmd_type cmd,
   output kstq_pkg::kstq_sts_type sts,
   input  wire logic [1:0]        req_type,
   input  wire logic [7:0]        req_scancode,
   input  wire logic              req_key_down,
   input  wire logic [3:0]        req_key_kind,
   input  wire logic [7:0]        req_plain_char,
   input  wire logic [7:0]        req_upper_char,
   input  wire logic [7:0]        req_pad_char,
   input  wire logic [15:0]       req_keystroke,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [15:0]            rsp_popped_word,
   output logic                   rsp_pop_ok,
   output logic                   rsp_push_ok,
   output logic                   rsp_ring_empty,
   output logic [15:0]            rsp_head_preview,
   output logic [7:0]             rsp_flag_byte,
   output logic                   rsp_break_event,
   output logic                   rsp_break_latched
);

   localparam int IDX_W = $clog2(RING_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   // captured request
   logic [1:0]  type_ff;
   logic [7:0]  scan_ff;
   logic        down_ff;
   logic [3:0]  kind_ff;
   logic [7:0]  plain_ff;
   logic [7:0]  upper_ff;
   logic [7:0]  pad_ff;
   logic [15:0] ks_ff;

   // architectural state
   logic [7:0]       flags_ff, flags_in;
   logic             caps_held_ff, caps_held_in;
   logic             num_held_ff, num_held_in;
   logic             scroll_held_ff, scroll_held_in;
   logic             sticky_ff, sticky_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;

   logic [15:0] ring_mem [RING_SLOTS];
   logic [15:0] rd_data_ff;

   // step results
   logic [15:0] popped_ff, popped_in;
   logic        pop_ok_ff, pop_ok_in;
   logic        push_ok_ff, push_ok_in;
   logic        brk_ff, brk_in;

   logic        want_push;
   logic [15:0] push_word;
   logic        do_write;
   logic        rsp_valid_ff;
   logic        ring_empty;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         scan_ff  <= req_scancode;
         down_ff  <= req_key_down;
         kind_ff  <= req_key_kind;
         plain_ff <= req_plain_char;
         upper_ff <= req_upper_char;
         pad_ff   <= req_pad_char;
         ks_ff    <= req_keystroke;
      end
   end

   always_comb begin
      flags_in       = flags_ff;
      caps_held_in   = caps_held_ff;
      num_held_in    = num_held_ff;
      scroll_held_in = scroll_held_ff;
      sticky_in      = sticky_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      popped_in      = 16'h0000;
      pop_ok_in      = 1'b0;
      push_ok_in     = 1'b0;
      brk_in         = 1'b0;
      want_push      = 1'b0;
      push_word      = ks_ff;
      do_write       = 1'b0;

      unique case (type_ff)
         kstq_pkg::REQ_KEY: begin
            unique case (kind_ff)
               kstq_pkg::KIND_LSHIFT:
                  flags_in = down_ff ? (flags_ff | kstq_pkg::MASK_LSHIFT)
                                     : (flags_ff & ~kstq_pkg::MASK_LSHIFT);
               kstq_pkg::KIND_RSHIFT:
                  flags_in = down_ff ? (flags_ff | kstq_pkg::MASK_RSHIFT)
                                     : (flags_ff & ~kstq_pkg::MASK_RSHIFT);
               kstq_pkg::KIND_CTRL:
                  flags_in = down_ff ? (flags_ff | kstq_pkg::MASK_CTRL)
                                     : (flags_ff & ~kstq_pkg::MASK_CTRL);
               kstq_pkg::KIND_ALT:
                  flags_in = down_ff ? (flags_ff | kstq_pkg::MASK_ALT)
                                     : (flags_ff & ~kstq_pkg::MASK_ALT);
               kstq_pkg::KIND_CAPS: begin
                  caps_held_in = down_ff;
                  if (down_ff && !caps_held_ff) flags_in = flags_ff ^ kstq_pkg::MASK_CAPS;
               end
               kstq_pkg::KIND_NUM: begin
                  num_held_in = down_ff;
                  if (down_ff && !num_held_ff) flags_in = flags_ff ^ kstq_pkg::MASK_NUM;
               end
               kstq_pkg::KIND_SCROLL: begin
                  if (down_ff && ((flags_ff & kstq_pkg::MASK_CTRL) != 8'h00)) begin
                     sticky_in = 1'b1;
                     brk_in    = 1'b1;
                  end else begin
                     scroll_held_in = down_ff;
                     if (down_ff && !scroll_held_ff)
                        flags_in = flags_ff ^ kstq_pkg::MASK_SCROLL;
                  end
               end
               kstq_pkg::KIND_LETTER, kstq_pkg::KIND_ASCII,
               kstq_pkg::KIND_NUMPAD, kstq_pkg::KIND_FUNC: begin
                  want_push = down_ff;
                  push_word = {scan_ff, kstq_pkg::translate_char(kind_ff, flags_ff,
                                                                 plain_ff, upper_ff, pad_ff)};
               end
               default: ;
            endcase
         end
         kstq_pkg::REQ_POP: begin
            if (head_ff != tail_ff) begin
               popped_in = rd_data_ff;
               pop_ok_in = 1'b1;
               head_in   = ring_next(head_ff);
            end
         end
         kstq_pkg::REQ_PUSH: want_push = 1'b1;
         default: ;
      endcase

      if (want_push && (ring_next(tail_ff) != head_ff)) begin
         do_write   = 1'b1;
         push_ok_in = 1'b1;
         tail_in    = ring_next(tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff       <= '0;
         caps_held_ff   <= 1'b0;
         num_held_ff    <= 1'b0;
         scroll_held_ff <= 1'b0;
         sticky_ff      <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
      end else if (cmd.execute) begin
         flags_ff       <= flags_in;
         caps_held_ff   <= caps_held_in;
         num_held_ff    <= num_held_in;
         scroll_held_ff <= scroll_held_in;
         sticky_ff      <= sticky_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         popped_ff  <= popped_in;
         pop_ok_ff  <= pop_ok_in;
         push_ok_ff <= push_ok_in;
         brk_ff     <= brk_in;
      end
   end

   // ring: one write port, head read every cycle
   always_ff @(posedge clock) begin
      if (cmd.execute && do_write) ring_mem[tail_ff] <= push_word;
      rd_data_ff <= ring_mem[head_ff];
   end

   assign ring_empty = (head_ff == tail_ff);

   // result register
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.publish) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_popped_word   <= popped_ff;
         rsp_pop_ok        <= pop_ok_ff;
         rsp_push_ok       <= push_ok_ff;
         rsp_ring_empty    <= ring_empty;
         rsp_head_preview  <= ring_empty ? 16'h0000 : rd_data_ff;
         rsp_flag_byte     <= flags_ff;
         rsp_break_event   <= brk_ff;
         rsp_break_latched <= sticky_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/kstq_checker.sv =====
`default_nettype none

module kstq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_popped_word,
   input wire logic        rsp_pop_ok,
   input wire logic        rsp_ring_empty,
   input wire logic [15:0] rsp_head_preview
);

   // a held response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // one request at a time: busy right after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_empty_preview: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ring_empty |-> rsp_head_preview == 16'h0000)
      else $error("head preview nonzero on empty ring");

   a_no_pop_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pop_ok |-> rsp_popped_word == 16'h0000)
      else $error("popped word nonzero without a pop");

endmodule

bind keyboard_scancode_translate_queue_unit kstq_checker u_kstq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_popped_word  (rsp_popped_word),
   .rsp_pop_ok       (rsp_pop_ok),
   .rsp_ring_empty   (rsp_ring_empty),
   .rsp_head_preview (rsp_head_preview)
);

`default_nettype wire

// ===== tb/sv/keyboard_scancode_translate_queue_unit_test.sv =====
`timescale 1ns / 100ps

module keyboard_scancode_translate_queue_unit_test;

   // Request code 3 is not decoded by the block: it only reports status.
   localparam logic [1:0] REQ_STATUS  = 2'd3;
   // Kind codes above scroll lock carry no meaning and must be ignored.
   localparam logic [3:0] KIND_SPARE  = 4'd15;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         DRAIN_WAIT  = 12;
   localparam int         MAX_REPORTS = 10;
   localparam int         RING_WORDS  = 15;   // 16 slots, one kept free

   typedef struct packed {
      logic [15:0] popped_word;
      logic        pop_ok;
      logic        push_ok;
      logic        ring_empty;
      logic [15:0] head_preview;
      logic [7:0]  flag_byte;
      logic        break_event;
      logic        break_latched;
   } kbd_status_type;

   // ---------------------------------------------------------------------
   // Block hookup. Every input starts at a known value.
   // ---------------------------------------------------------------------
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [1:0]  req_type       = kstq_pkg::REQ_KEY;
   logic [7:0]  req_scancode   = 8'h00;
   logic        req_key_down   = 1'b0;
   logic [3:0]  req_key_kind   = kstq_pkg::KIND_UNMAPPED;
   logic [7:0]  req_plain_char = 8'h00;
   logic [7:0]  req_upper_char = 8'h00;
   logic [7:0]  req_pad_char   = 8'h00;
   logic [15:0] req_keystroke  = 16'h0000;
   logic        rsp_stall      = 1'b0;

   logic        req_stall;
   logic        rsp_valid;
   logic [15:0] rsp_popped_word;
   logic        rsp_pop_ok;
   logic        rsp_push_ok;
   logic        rsp_ring_empty;
   logic [15:0] rsp_head_preview;
   logic [7:0]  rsp_flag_byte;
   logic        rsp_break_event;
   logic        rsp_break_latched;

   keyboard_scancode_translate_queue_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_scancode      (req_scancode),
      .req_key_down      (req_key_down),
      .req_key_kind      (req_key_kind),
      .req_plain_char    (req_plain_char),
      .req_upper_char    (req_upper_char),
      .req_pad_char      (req_pad_char),
      .req_keystroke     (req_keystroke),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_popped_word   (rsp_popped_word),
      .rsp_pop_ok        (rsp_pop_ok),
      .rsp_push_ok       (rsp_push_ok),
      .rsp_ring_empty    (rsp_ring_empty),
      .rsp_head_preview  (rsp_head_preview),
      .rsp_flag_byte     (rsp_flag_byte),
      .rsp_break_event   (rsp_break_event),
      .rsp_break_latched (rsp_break_latched)
   );

   // ---------------------------------------------------------------------
   // Keyboard buffer shadow: flags, lock-held bits, break flag and the
   // keystroke ring, advanced once per accepted request beat.
   // ---------------------------------------------------------------------
   logic [7:0]  kb_flags       = 8'h00;
   logic        kb_caps_held   = 1'b0;
   logic        kb_num_held    = 1'b0;
   logic        kb_scroll_held = 1'b0;
   logic        kb_break       = 1'b0;
   logic [15:0] kb_ring [16];
   logic [3:0]  kb_head        = 4'd0;
   logic [3:0]  kb_tail        = 4'd0;

   kbd_status_type status_due [$];   // expected status beats, oldest first
   kbd_status_type seen_status;
   kbd_status_type due_status;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Character byte of a translated word; uses the flags before the event.
   function automatic logic [7:0] xlate_char(input logic [3:0] kind,
                                             input logic [7:0] plain,
                                             input logic [7:0] upper,
                                             input logic [7:0] pad);
      logic shifted;
      logic ctrl_on;
      logic caps_on;
      logic num_on;
      shifted = |(kb_flags & (kstq_pkg::MASK_LSHIFT | kstq_pkg::MASK_RSHIFT));
      ctrl_on = |(kb_flags & kstq_pkg::MASK_CTRL);
      caps_on = |(kb_flags & kstq_pkg::MASK_CAPS);
      num_on  = |(kb_flags & kstq_pkg::MASK_NUM);
      case (kind)
         kstq_pkg::KIND_LETTER: begin
            // control code, case flip, or as is; all modulo 256
            if (ctrl_on) return plain - (kstq_pkg::CHAR_LOWER_A - 8'd1);
            if (shifted ^ caps_on)
               return plain - (kstq_pkg::CHAR_LOWER_A - kstq_pkg::CHAR_UPPER_A);
            return plain;
         end
         kstq_pkg::KIND_ASCII:  return shifted ? upper : plain;
         kstq_pkg::KIND_NUMPAD: return (num_on ^ shifted) ? pad : 8'h00;
         default:               return 8'h00;
      endcase
   endfunction

   // Store a word at the tail; a full ring drops it.
   function automatic logic ring_store(input logic [15:0] word);
      logic [3:0] next_tail;
      next_tail = kb_tail + 4'd1;
      if (next_tail == kb_head) return 1'b0;
      kb_ring[kb_tail] = word;
      kb_tail = next_tail;
      return 1'b1;
   endfunction

   // Lock keys toggle only on a fresh press, not on auto-repeat.
   task automatic toggle_lock(input logic down, input logic [7:0] mask,
                              inout logic held);
      if (!down) begin
         held = 1'b0;
      end else if (!held) begin
         held = 1'b1;
         kb_flags = kb_flags ^ mask;
      end
   endtask

   // Modifier keys follow the key: set on press, clear on release.
   function automatic logic [7:0] modifier(input logic down, input logic [7:0] mask);
      return down ? (kb_flags | mask) : (kb_flags & ~mask);
   endfunction

   task automatic predict_status(input logic [1:0] rtype, input logic [7:0] sc,
                                 input logic down, input logic [3:0] kind,
                                 input logic [7:0] plain, input logic [7:0] upper,
                                 input logic [7:0] pad, input logic [15:0] ks);
      kbd_status_type due;
      due = '0;
      case (rtype)
         kstq_pkg::REQ_KEY: begin
            case (kind)
               kstq_pkg::KIND_LSHIFT: kb_flags = modifier(down, kstq_pkg::MASK_LSHIFT);
               kstq_pkg::KIND_RSHIFT: kb_flags = modifier(down, kstq_pkg::MASK_RSHIFT);
               kstq_pkg::KIND_CTRL:   kb_flags = modifier(down, kstq_pkg::MASK_CTRL);
               kstq_pkg::KIND_ALT:    kb_flags = modifier(down, kstq_pkg::MASK_ALT);
               kstq_pkg::KIND_CAPS:
                  toggle_lock(down, kstq_pkg::MASK_CAPS, kb_caps_held);
               kstq_pkg::KIND_NUM:
                  toggle_lock(down, kstq_pkg::MASK_NUM, kb_num_held);
               kstq_pkg::KIND_SCROLL: begin
                  // ctrl + scroll press is Ctrl-Break; its release is a
                  // plain scroll release
                  if (down && |(kb_flags & kstq_pkg::MASK_CTRL)) begin
                     kb_break = 1'b1;
                     due.break_event = 1'b1;
                  end else begin
                     toggle_lock(down, kstq_pkg::MASK_SCROLL, kb_scroll_held);
                  end
               end
               kstq_pkg::KIND_LETTER, kstq_pkg::KIND_ASCII,
               kstq_pkg::KIND_NUMPAD, kstq_pkg::KIND_FUNC: begin
                  if (down) due.push_ok = ring_store({sc, xlate_char(kind, plain, upper, pad)});
               end
               default: ;
            endcase
         end
         kstq_pkg::REQ_POP: begin
            if (kb_head != kb_tail) begin
               due.popped_word = kb_ring[kb_head];
               due.pop_ok = 1'b1;
               kb_head = kb_head + 4'd1;
            end
         end
         kstq_pkg::REQ_PUSH: due.push_ok = ring_store(ks);
         default: ;
      endcase
      due.ring_empty    = (kb_head == kb_tail);
      due.head_preview  = due.ring_empty ? 16'h0000 : kb_ring[kb_head];
      due.flag_byte     = kb_flags;
      due.break_latched = kb_break;
      status_due.push_back(due);
   endtask

   // ---------------------------------------------------------------------
   // Request driver. Called on a rising edge, returns on the edge that
   // accepts the beat. Valid is only lowered for an idle gap, so back to
   // back beats never see valid dropped and raised in one step.
   // ---------------------------------------------------------------------
   task automatic send_beat(input logic [1:0] rtype, input logic [7:0] sc,
                            input logic down, input logic [3:0] kind,
                            input logic [7:0] plain, input logic [7:0] upper,
                            input logic [7:0] pad, input logic [15:0] ks);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= rtype;
      req_scancode   <= sc;
      req_key_down   <= down;
      req_key_kind   <= kind;
      req_plain_char <= plain;
      req_upper_char <= upper;
      req_pad_char   <= pad;
      req_keystroke  <= ks;
      do @(posedge clock); while (req_stall);
      predict_status(rtype, sc, down, kind, plain, upper, pad, ks);
   endtask

   // Fields a request does not use still get random values.
   task automatic send_key(input logic [3:0] kind, input logic [7:0] sc,
                           input logic down, input logic [7:0] plain,
                           input logic [7:0] upper, input logic [7:0] pad);
      send_beat(kstq_pkg::REQ_KEY, sc, down, kind, plain, upper, pad, 16'($urandom));
   endtask

   task automatic send_pop();
      send_beat(kstq_pkg::REQ_POP, 8'($urandom), 1'($urandom), 4'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic send_enqueue(input logic [15:0] ks);
      send_beat(kstq_pkg::REQ_PUSH, 8'($urandom), 1'($urandom), 4'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), ks);
   endtask

   // Ordinary key, mostly letters, most of them lowercase.
   task automatic send_random_char_key(input logic down);
      logic [3:0] kind;
      logic [7:0] plain;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)      kind = kstq_pkg::KIND_LETTER;
      else if (pick < 8) kind = kstq_pkg::KIND_ASCII;
      else if (pick < 9) kind = kstq_pkg::KIND_NUMPAD;
      else               kind = kstq_pkg::KIND_FUNC;
      if (kind == kstq_pkg::KIND_LETTER && $urandom_range(0, 4) != 0)
         plain = 8'($urandom_range(kstq_pkg::CHAR_LOWER_A, kstq_pkg::CHAR_LOWER_A + 25));
      else
         plain = 8'($urandom);
      send_key(kind, 8'($urandom), down, plain, 8'($urandom), 8'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_status = {rsp_popped_word, rsp_pop_ok, rsp_push_ok, rsp_ring_empty,
                        rsp_head_preview, rsp_flag_byte, rsp_break_event,
                        rsp_break_latched};
         if (status_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected status beat, got %h", $realtime, seen_status);
         end else begin
            due_status = status_due.pop_front();
            if (seen_status !== due_status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: status beat differs", $realtime);
                  $display("  exp pop %h/%b push %b empty %b head %h flags %h brk %b/%b",
                           due_status.popped_word, due_status.pop_ok,
                           due_status.push_ok, due_status.ring_empty,
                           due_status.head_preview, due_status.flag_byte,
                           due_status.break_event, due_status.break_latched);
                  $display("  got pop %h/%b push %b empty %b head %h flags %h brk %b/%b",
                           seen_status.popped_word, seen_status.pop_ok,
                           seen_status.push_ok, seen_status.ring_empty,
                           seen_status.head_preview, seen_status.flag_byte,
                           seen_status.break_event, seen_status.break_latched);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Pop on empty, direct enqueue of extreme words, undecoded request.
   task automatic test_ring_basics();
      send_pop();
      send_enqueue(16'hFFFF);
      send_enqueue(16'h0000);
      send_beat(REQ_STATUS, 8'hFF, 1'b1, kstq_pkg::KIND_LETTER, 8'hFF, 8'hFF, 8'hFF,
                16'hFFFF);
      send_pop();
      send_pop();
   endtask

   // Letter/ascii/function translation, shift, ignored keys, releases.
   task automatic test_translation();
      send_key(kstq_pkg::KIND_LETTER, 8'h1E, 1'b1, kstq_pkg::CHAR_LOWER_A,
               kstq_pkg::CHAR_UPPER_A, 8'h00);
      send_key(kstq_pkg::KIND_LETTER, 8'h9E, 1'b0, kstq_pkg::CHAR_LOWER_A,
               kstq_pkg::CHAR_UPPER_A, 8'h00);
      send_key(kstq_pkg::KIND_UNMAPPED, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(KIND_SPARE, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_key(kstq_pkg::KIND_LSHIFT, 8'h2A, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_LETTER, 8'h10, 1'b1, kstq_pkg::CHAR_LOWER_A + 8'd16,
               8'h51, 8'h00);
      send_key(kstq_pkg::KIND_ASCII, 8'h02, 1'b1, 8'h31, 8'h21, 8'h00);   // '1' / '!'
      send_key(kstq_pkg::KIND_LSHIFT, 8'hAA, 1'b0, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_FUNC, 8'h3B, 1'b1, 8'h00, 8'h00, 8'h00);
   endtask

   // Caps with auto-repeat, num lock on the keypad, shift cancels num lock.
   task automatic test_lock_keys();
      send_key(kstq_pkg::KIND_CAPS, 8'h3A, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_CAPS, 8'h3A, 1'b1, 8'h00, 8'h00, 8'h00);   // repeat: no toggle
      send_key(kstq_pkg::KIND_LETTER, 8'h25, 1'b1, kstq_pkg::CHAR_LOWER_A + 8'd10,
               8'h4B, 8'h00);
      send_key(kstq_pkg::KIND_NUM, 8'h45, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_NUMPAD, 8'h47, 1'b1, 8'h00, 8'h00, 8'h37);
      send_key(kstq_pkg::KIND_RSHIFT, 8'h36, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_NUMPAD, 8'h47, 1'b1, 8'h00, 8'h00, 8'h37);
      send_key(kstq_pkg::KIND_RSHIFT, 8'hB6, 1'b0, 8'h00, 8'h00, 8'h00);
   endtask

   // Ctrl letter codes, Ctrl-Break and its release, alt.
   task automatic test_ctrl_break();
      send_key(kstq_pkg::KIND_CTRL, 8'h1D, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_LETTER, 8'h2E, 1'b1, kstq_pkg::CHAR_LOWER_A + 8'd2,
               8'h43, 8'h00);
      send_key(kstq_pkg::KIND_SCROLL, 8'h46, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_SCROLL, 8'hC6, 1'b0, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_CTRL, 8'h9D, 1'b0, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_ALT, 8'h38, 1'b1, 8'h00, 8'h00, 8'h00);
      send_key(kstq_pkg::KIND_ALT, 8'hB8, 1'b0, 8'h00, 8'h00, 8'h00);
   endtask

   // Realistic key traffic: presses, releases, modifiers, locks, pops.
   task automatic test_typing_session(input int beats);
      int unsigned pick;
      repeat (beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            send_random_char_key(1'b1);
         else if (pick < 42)
            send_random_char_key(1'b0);
         else if (pick < 60)
            send_key(4'($urandom_range(kstq_pkg::KIND_LSHIFT, kstq_pkg::KIND_ALT)),
                     8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
         else if (pick < 70)
            send_key(4'($urandom_range(kstq_pkg::KIND_CAPS, kstq_pkg::KIND_SCROLL)),
                     8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
         else if (pick < 92)
            send_pop();
         else
            send_enqueue(16'($urandom));
      end
   endtask

   // Fill past capacity so words get dropped, then drain past empty.
   task automatic test_ring_overflow();
      int fill;
      fill = RING_WORDS - int'(4'(kb_tail - kb_head)) + 2;
      repeat (fill) begin
         if ($urandom_range(0, 1) != 0) send_enqueue(16'($urandom));
         else send_random_char_key(1'b1);
      end
      repeat (RING_WORDS + 2) send_pop();
   endtask

   // Unconstrained beats: undecoded request and kind codes included.
   task automatic test_random_noise(input int beats);
      repeat (beats)
         send_beat(2'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // light sender gaps, heavy receiver back-pressure
      send_idle_pct = 18;
      recv_idle_pct = 73;
      test_ring_basics();
      test_translation();
      test_lock_keys();
      test_ctrl_break();
      test_typing_session(100);
      test_ring_overflow();
      test_random_noise(25);

      // heavy sender gaps, light back-pressure
      send_idle_pct = 73;
      recv_idle_pct = 18;
      test_typing_session(100);
      test_ring_overflow();
      test_random_noise(25);

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_typing_session(100);
      test_ring_overflow();
      test_random_noise(25);

      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
